@@ src/battery_pack_monitor_defines.svh @@
// ---------------------------------------------------------------------------
// battery_pack_monitor_defines
// Assertion macros used by the battery pack monitor top level.
// ---------------------------------------------------------------------------
`ifndef BATTERY_PACK_MONITOR_DEFINES_SVH
`define BATTERY_PACK_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bpm_pkg.sv @@
// ---------------------------------------------------------------------------
// bpm_pkg
// Shared constants, types and tap gains of the battery pack monitor.
// ---------------------------------------------------------------------------
package bpm_pkg;

  localparam int NUM_BATTERIES_DEF = 3;
  localparam int SENSORS_DEF       = 2;

  localparam int NUM_TAPS  = 6;
  localparam int RAW_W     = 12;
  localparam int GAIN_W    = 19;
  localparam int MV_W      = 15;
  localparam int CELL_W    = 16;
  localparam int TEMP_W    = 9;
  localparam int WEIGHT_W  = 9;
  localparam int LIMIT_W   = 15;
  localparam int BATT_W    = 2;
  localparam int ALARM_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 136;

  // Q16 gains: round(65536 * 5000 * cal / 4095).
  localparam logic [GAIN_W-1:0] TAP_GAIN_Q16 [NUM_TAPS] = '{
    19'd160039, 19'd160039, 19'd240059, 19'd320078, 19'd401698, 19'd479317
  };

  localparam logic [LIMIT_W-1:0]  SPREAD_LIMIT_RST = 15'd500;
  localparam logic [TEMP_W-1:0]   TEMP_HIGH_RST    = 9'd60;
  localparam logic [TEMP_W-1:0]   TEMP_LOW_RST     = 9'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST       = 9'd128;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = 9'd256;

  localparam int ALARM_TEMP_BIT      = 0;
  localparam int ALARM_IMBALANCE_BIT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREAD_LIMIT = 2'd0,
    CFG_TEMP_HIGH    = 2'd1,
    CFG_TEMP_LOW     = 2'd2,
    CFG_AVG_WEIGHT   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic batt_ok;
    logic eop;
    logic temp_alarm;
  } stage_ctrl_t;

endpackage

@@ src/bpm_tap_lane.sv @@
// ---------------------------------------------------------------------------
// bpm_tap_lane
// One tap scaling lane: raw reading times Q16 gain, rounded, registered.
// ---------------------------------------------------------------------------
module bpm_tap_lane
  import bpm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAW_W-1:0]  raw,
  input  logic [GAIN_W-1:0] gain,
  output logic [MV_W-1:0]   mv
);

  logic [31:0] product;
  logic [31:0] rounded;

  assign product = 32'(raw) * 32'(gain);
  assign rounded = product + 32'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      mv <= rounded[16 +: MV_W];
    end
  end

endmodule

@@ src/bpm_temp_lane.sv @@
// ---------------------------------------------------------------------------
// bpm_temp_lane
// One thermistor lane: per-battery Q8 exponential average and range check.
// ---------------------------------------------------------------------------
module bpm_temp_lane
  import bpm_pkg::*;
#(
  parameter int NUM_BATTERIES = NUM_BATTERIES_DEF
)(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     upd,
  input  logic [NUM_BATTERIES-1:0] hit,
  input  logic                     seeded,
  input  logic [WEIGHT_W-1:0]      weight,
  input  logic signed [TEMP_W-1:0] sample,
  input  logic signed [TEMP_W-1:0] high_limit,
  input  logic signed [TEMP_W-1:0] low_limit,
  output logic signed [TEMP_W-1:0] avg_new,
  output logic                     out_of_range
);

  logic signed [TEMP_W-1:0] avg_store [NUM_BATTERIES];
  logic signed [TEMP_W-1:0] avg_old;
  logic [WEIGHT_W-1:0]      weight_new;
  logic signed [18:0]       prod_old;
  logic signed [18:0]       prod_new;
  logic signed [19:0]       sum;
  logic signed [19:0]       sum_adj;
  logic signed [19:0]       quot;

  always_comb begin
    avg_old = '0;
    for (int b = 0; b < NUM_BATTERIES; b++) begin
      if (hit[b]) begin
        avg_old = avg_old | avg_store[b];
      end
    end
  end

  assign weight_new = WEIGHT_ONE - weight;
  assign prod_old   = $signed({1'b0, weight}) * avg_old;
  assign prod_new   = $signed({1'b0, weight_new}) * sample;
  assign sum        = {prod_old[18], prod_old} + {prod_new[18], prod_new};
  // Round toward zero on the divide by 256.
  assign sum_adj    = sum[19] ? (sum + 20'sd255) : sum;
  assign quot       = sum_adj >>> 8;
  assign avg_new    = seeded ? quot[TEMP_W-1:0] : sample;
  assign out_of_range = (avg_new > high_limit) || (avg_new < low_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BATTERIES; b++) begin
        avg_store[b] <= '0;
      end
    end else if (upd) begin
      for (int b = 0; b < NUM_BATTERIES; b++) begin
        if (hit[b]) begin
          avg_store[b] <= avg_new;
        end
      end
    end
  end

endmodule

@@ src/bpm_merge.sv @@
// ---------------------------------------------------------------------------
// bpm_merge
// Merge stage: cell differences, spread check, pending and latched alarms.
// ---------------------------------------------------------------------------
module bpm_merge
  import bpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  stage_ctrl_t              ctrl,
  input  logic [MV_W-1:0]          tap_mv [NUM_TAPS],
  input  logic [LIMIT_W-1:0]       spread_limit,
  output logic signed [CELL_W-1:0] cell_mv [NUM_TAPS],
  output logic [ALARM_W-1:0]       alarm_next
);

  logic [ALARM_W-1:0]       pending;
  logic [ALARM_W-1:0]       latch;
  logic [ALARM_W-1:0]       pending_next;
  logic [ALARM_W-1:0]       pending_upd;
  logic signed [CELL_W-1:0] cell_lo;
  logic signed [CELL_W-1:0] cell_hi;
  logic signed [CELL_W:0]   spread;
  logic                     imbalance;

  always_comb begin
    cell_mv[0] = $signed({1'b0, tap_mv[0]});
    for (int k = 1; k < NUM_TAPS; k++) begin
      cell_mv[k] = $signed({1'b0, tap_mv[k]}) - $signed({1'b0, tap_mv[k-1]});
    end
  end

  always_comb begin
    cell_lo = cell_mv[0];
    cell_hi = cell_mv[0];
    for (int k = 1; k < NUM_TAPS; k++) begin
      if (cell_mv[k] < cell_lo) cell_lo = cell_mv[k];
      if (cell_mv[k] > cell_hi) cell_hi = cell_mv[k];
    end
  end

  assign spread    = {cell_hi[CELL_W-1], cell_hi} - {cell_lo[CELL_W-1], cell_lo};
  assign imbalance = ctrl.batt_ok && (spread > $signed({2'b00, spread_limit}));

  always_comb begin
    pending_upd = pending;
    pending_upd[ALARM_IMBALANCE_BIT] = pending[ALARM_IMBALANCE_BIT] | imbalance;
    pending_upd[ALARM_TEMP_BIT]      = pending[ALARM_TEMP_BIT] | ctrl.temp_alarm;
    if (ctrl.eop) begin
      // Imbalance stays latched once raised, and then so does temperature; else the word follows the pass.
      alarm_next   = latch[ALARM_IMBALANCE_BIT] ? (latch | pending_upd) : pending_upd;
      pending_next = '0;
    end else begin
      alarm_next   = latch;
      pending_next = pending_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      latch   <= '0;
    end else if (load) begin
      pending <= pending_next;
      latch   <= alarm_next;
    end
  end

endmodule

@@ src/battery_pack_monitor.sv @@
// ---------------------------------------------------------------------------
// battery_pack_monitor
// Per-battery cell voltage, pack voltage and temperature average monitor.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  one battery's taps and temperatures, tlast = end of pass
// m_*      out  m_tvalid/m_tready  cell and pack voltages, averages, alarm word
// cfg_*    in   cfg_we             register writes, no read-back
//
// One request per cycle sustained while the sink keeps m_tready high. A
// request passes the stage register, then the output register, to m_tvalid. Six
// tap lanes multiply in parallel into the stage register and the
// temperature lanes update their averages at acceptance; the merge stage forms
// the cells, the min/max spread and the alarm word into the output register.
// Reset (rst, synchronous) empties both stages and clears averages, seeded
// flags and alarms. When m_tready is low the output register holds, and the
// stage register still takes one more request.
//
module battery_pack_monitor
  import bpm_pkg::*;
#(
  parameter int NUM_BATTERIES       = NUM_BATTERIES_DEF,
  parameter int SENSORS_PER_BATTERY = SENSORS_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: battery_index[1:0], tap0_raw..tap5_raw[73:2] (12 bits each),
  //          temp_a_now[82:74], temp_b_now[91:83], zero[95:92]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  // m_tdata: battery_out[1:0], cell0_mv..cell5_mv[97:2] (16 bits each),
  //          pack_mv[112:98], temp_a_avg[121:113], temp_b_avg[130:122],
  //          alarm_word[132:131], zero[135:133]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

`include "battery_pack_monitor_defines.svh"

  // Configuration registers.
  logic [LIMIT_W-1:0]       spread_limit;
  logic signed [TEMP_W-1:0] temp_high;
  logic signed [TEMP_W-1:0] temp_low;
  logic [WEIGHT_W-1:0]      avg_weight;
  logic [WEIGHT_W-1:0]      weight_eff;

  // Handshake.
  logic s_accept;
  logic s1_valid;
  logic s2_load;
  logic out_valid;

  // Input side.
  logic [BATT_W-1:0]        in_batt;
  logic signed [TEMP_W-1:0] in_temp [2];
  logic [NUM_BATTERIES-1:0] hit;
  logic                     batt_ok;
  logic [NUM_BATTERIES-1:0] seeded;
  logic                     seeded_hit;
  logic signed [TEMP_W-1:0] lane_avg [2];
  logic [1:0]               lane_oor;
  logic signed [TEMP_W-1:0] avg_sel [2];
  logic                     temp_alarm;

  // Stage register.
  logic [BATT_W-1:0]        s1_batt;
  logic signed [TEMP_W-1:0] s1_avg [2];
  stage_ctrl_t              s1_ctrl;
  logic [MV_W-1:0]          tap_mv [NUM_TAPS];

  // Merge results and output register.
  logic signed [CELL_W-1:0] cell_mv [NUM_TAPS];
  logic [ALARM_W-1:0]       alarm_next;
  logic [BATT_W-1:0]        out_batt;
  logic signed [CELL_W-1:0] out_cell [NUM_TAPS];
  logic [MV_W-1:0]          out_pack;
  logic signed [TEMP_W-1:0] out_avg [2];
  logic [ALARM_W-1:0]       out_alarm;

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_limit <= SPREAD_LIMIT_RST;
      temp_high    <= TEMP_HIGH_RST;
      temp_low     <= TEMP_LOW_RST;
      avg_weight   <= WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_SPREAD_LIMIT: spread_limit <= cfg_data;
        CFG_TEMP_HIGH:    temp_high    <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_LOW:     temp_low     <= cfg_data[TEMP_W-1:0];
        CFG_AVG_WEIGHT:   avg_weight   <= cfg_data[WEIGHT_W-1:0];
      endcase
    end
  end

  // Any weight at or above one full step freezes the average.
  assign weight_eff = avg_weight[WEIGHT_W-1] ? WEIGHT_ONE : avg_weight;

  // ---- handshake: stage register, then output register ----
  assign s2_load  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s2_load;
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- input decode ----
  assign in_batt    = s_tdata[BATT_W-1:0];
  assign in_temp[0] = $signed(s_tdata[74 +: TEMP_W]);
  assign in_temp[1] = $signed(s_tdata[83 +: TEMP_W]);

  always_comb begin
    for (int b = 0; b < NUM_BATTERIES; b++) begin
      hit[b] = (int'(in_batt) == b);
    end
  end

  // Out-of-range battery numbers touch no average or seeded state and raise nothing.
  assign batt_ok    = |hit;
  assign seeded_hit = |(seeded & hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= '0;
    end else if (s_accept && batt_ok) begin
      seeded <= seeded | hit;
    end
  end

  // ---- tap lanes ----
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    bpm_tap_lane u_lane (
      .clk  (clk),
      .en   (s_accept),
      .raw  (s_tdata[BATT_W + RAW_W*k +: RAW_W]),
      .gain (TAP_GAIN_Q16[k]),
      .mv   (tap_mv[k])
    );
  end

  // ---- temperature lanes ----
  for (genvar s = 0; s < 2; s++) begin : g_temp
    if (s < SENSORS_PER_BATTERY) begin : g_on
      bpm_temp_lane #(
        .NUM_BATTERIES (NUM_BATTERIES)
      ) u_lane (
        .clk          (clk),
        .rst          (rst),
        .upd          (s_accept && batt_ok),
        .hit          (hit),
        .seeded       (seeded_hit),
        .weight       (weight_eff),
        .sample       (in_temp[s]),
        .high_limit   (temp_high),
        .low_limit    (temp_low),
        .avg_new      (lane_avg[s]),
        .out_of_range (lane_oor[s])
      );
      assign avg_sel[s] = batt_ok ? lane_avg[s] : in_temp[s];
    end else begin : g_off
      // Untracked sensor: report zero, raise nothing.
      assign lane_avg[s] = '0;
      assign lane_oor[s] = 1'b0;
      assign avg_sel[s]  = '0;
    end
  end

  assign temp_alarm = batt_ok && (|lane_oor);

  // ---- stage register payload ----
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_batt            <= in_batt;
      s1_avg[0]          <= avg_sel[0];
      s1_avg[1]          <= avg_sel[1];
      s1_ctrl.batt_ok    <= batt_ok;
      s1_ctrl.eop        <= s_tlast;
      s1_ctrl.temp_alarm <= temp_alarm;
    end
  end

  // ---- merge stage ----
  bpm_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (s2_load),
    .ctrl         (s1_ctrl),
    .tap_mv       (tap_mv),
    .spread_limit (spread_limit),
    .cell_mv      (cell_mv),
    .alarm_next   (alarm_next)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_batt   <= s1_batt;
      out_cell   <= cell_mv;
      out_pack   <= tap_mv[NUM_TAPS-1];
      out_avg[0] <= s1_avg[0];
      out_avg[1] <= s1_avg[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_alarm <= '0;
    end else if (s2_load) begin
      out_alarm <= alarm_next;
    end
  end

  assign m_tdata = {3'b000, out_alarm, out_avg[1], out_avg[0], out_pack,
                    out_cell[5], out_cell[4], out_cell[3],
                    out_cell[2], out_cell[1], out_cell[0], out_batt};

  // ---- assertions ----
  `BPM_ASSERT_NEXT(a_stage_hold, s1_valid && !s2_load, s1_valid, "stage request dropped while stalled")
  `BPM_ASSERT_NOW(a_imbalance_sticky, s2_load && out_alarm[ALARM_IMBALANCE_BIT], alarm_next[ALARM_IMBALANCE_BIT], "imbalance alarm cleared")
  `BPM_ASSERT_NOW(a_bad_batt_quiet, s1_valid && !s1_ctrl.batt_ok, !s1_ctrl.temp_alarm, "alarm from unknown battery")

endmodule

@@ tb/bpm_monitor_checker.sv @@
// ---------------------------------------------------------------------------
// bpm_monitor_checker
// Watches the battery pack monitor's channels, predicts every report from
// the accepted readings and compares each delivered report field by field.
// ---------------------------------------------------------------------------
module bpm_monitor_checker
  import bpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data,
  output int                    fail_count,
  output int                    reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEMP_A_LSB = BATT_W + RAW_W * NUM_TAPS;
  localparam int TEMP_B_LSB = TEMP_A_LSB + TEMP_W;

  // Declared from the top of m_tdata down, so the cast lines up with the bus.
  typedef struct packed {
    logic [ALARM_W-1:0]              alarm;
    logic [TEMP_W-1:0]               temp_b_avg;
    logic [TEMP_W-1:0]               temp_a_avg;
    logic [MV_W-1:0]                 pack_mv;
    logic [NUM_TAPS-1:0][CELL_W-1:0] cell_mv;
    logic [BATT_W-1:0]               battery;
  } pack_report_t;

  localparam int REPORT_W = $bits(pack_report_t);

  int unsigned        spread_limit;
  int                 temp_high;
  int                 temp_low;
  int unsigned        avg_weight;
  int                 temp_avg [NUM_BATTERIES_DEF][2];
  bit                 avg_seeded [NUM_BATTERIES_DEF];
  logic [ALARM_W-1:0] pending_alarm;
  logic [ALARM_W-1:0] alarm_latch;
  pack_report_t       expected_reports [$];
  int                 mismatches = 0;

  function automatic void clear_monitor_state();
    spread_limit  = int'(SPREAD_LIMIT_RST);
    temp_high     = int'($signed(TEMP_HIGH_RST));
    temp_low      = int'($signed(TEMP_LOW_RST));
    avg_weight    = int'(WEIGHT_RST);
    pending_alarm = '0;
    alarm_latch   = '0;
    for (int b = 0; b < NUM_BATTERIES_DEF; b++) begin
      temp_avg[b][0] = 0;
      temp_avg[b][1] = 0;
      avg_seeded[b]  = 1'b0;
    end
  endfunction

  function automatic void write_limit_reg(logic [CFG_IDX_W-1:0] idx,
                                          logic [LIMIT_W-1:0] value);
    case (cfg_reg_e'(idx))
      CFG_SPREAD_LIMIT: spread_limit = int'(value);
      CFG_TEMP_HIGH:    temp_high    = int'($signed(value[TEMP_W-1:0]));
      CFG_TEMP_LOW:     temp_low     = int'($signed(value[TEMP_W-1:0]));
      CFG_AVG_WEIGHT:   avg_weight   = int'(value[WEIGHT_W-1:0]);
      default: ;
    endcase
  endfunction

  // Advance the monitor by one battery reading and return its report.
  function automatic pack_report_t predict_report(logic [IN_DATA_W-1:0] d, logic eop);
    pack_report_t r;
    longint       tap_mv [NUM_TAPS];
    longint       cell_now, lo, hi, prev;
    int           temp_now [2];
    int           avg [2];
    int           batt, w, a;
    bit           known;
    batt  = int'(d[BATT_W-1:0]);
    known = batt < NUM_BATTERIES_DEF;
    prev  = 0;
    lo    = 0;
    hi    = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      tap_mv[k] = (longint'(d[BATT_W + RAW_W*k +: RAW_W]) * longint'(TAP_GAIN_Q16[k])
                   + 32768) >> 16;
      cell_now = tap_mv[k] - prev;
      prev = tap_mv[k];
      r.cell_mv[k] = CELL_W'(cell_now);
      if (k == 0 || cell_now < lo) lo = cell_now;
      if (k == 0 || cell_now > hi) hi = cell_now;
    end
    // Strict compare over all six cells; unknown batteries raise nothing.
    if (known && (hi - lo) > longint'(spread_limit))
      pending_alarm[ALARM_IMBALANCE_BIT] = 1'b1;

    temp_now[0] = int'($signed(d[TEMP_A_LSB +: TEMP_W]));
    temp_now[1] = int'($signed(d[TEMP_B_LSB +: TEMP_W]));
    avg[0] = temp_now[0];
    avg[1] = (SENSORS_DEF > 1) ? temp_now[1] : 0;
    w = (avg_weight > 256) ? 256 : int'(avg_weight);
    if (known) begin
      for (int s = 0; s < SENSORS_DEF && s < 2; s++) begin
        // First reading seeds; later ones blend, truncating toward zero.
        if (avg_seeded[batt])
          a = (w * temp_avg[batt][s] + (256 - w) * temp_now[s]) / 256;
        else
          a = temp_now[s];
        temp_avg[batt][s] = a;
        avg[s] = a;
        if (a > temp_high || a < temp_low) pending_alarm[ALARM_TEMP_BIT] = 1'b1;
      end
      avg_seeded[batt] = 1'b1;
    end

    // Imbalance is sticky: once latched, merges only add bits.
    if (eop) begin
      if (!alarm_latch[ALARM_IMBALANCE_BIT]) alarm_latch = pending_alarm;
      else alarm_latch = alarm_latch | pending_alarm;
      pending_alarm = '0;
    end

    r.battery    = d[BATT_W-1:0];
    r.pack_mv    = MV_W'(tap_mv[NUM_TAPS-1]);
    r.temp_a_avg = TEMP_W'(avg[0]);
    r.temp_b_avg = TEMP_W'(avg[1]);
    r.alarm      = alarm_latch;
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pack_report_t want;
    pack_report_t got;
    if (rst) begin
      clear_monitor_state();
      expected_reports.delete();
    end else begin
      if (cfg_we) write_limit_reg(cfg_index, cfg_data);
      // Check the outgoing report before queuing the incoming request.
      if (m_tvalid && m_tready) begin
        got = pack_report_t'(m_tdata[REPORT_W-1:0]);
        if (expected_reports.size() == 0) begin
          $error("report for battery %0d with none outstanding", got.battery);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("battery_out", want.battery, got.battery);
          for (int k = 0; k < NUM_TAPS; k++)
            compare_field($sformatf("cell%0d_mv", k),
                          $signed(want.cell_mv[k]), $signed(got.cell_mv[k]));
          compare_field("pack_mv", want.pack_mv, got.pack_mv);
          compare_field("temp_a_avg", $signed(want.temp_a_avg), $signed(got.temp_a_avg));
          compare_field("temp_b_avg", $signed(want.temp_b_avg), $signed(got.temp_b_avg));
          compare_field("alarm_word", want.alarm, got.alarm);
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(predict_report(s_tdata, s_tlast));
    end
    fail_count  <= mismatches;
    reports_due <= expected_reports.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Drives battery readings and limit writes into the battery pack monitor,
// with random source gaps and sink back-pressure, and reports the verdict
// from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpm_pkg::*;

  localparam int BLOCK_READINGS = 322;   // six random blocks, ~1950 requests total
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int LONG_STALL     = 300;   // sink hold-off that backs up the input

  localparam int TAPS_W = NUM_TAPS * RAW_W;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  cfg_reg_e              cfg_index = CFG_SPREAD_LIMIT;
  logic [LIMIT_W-1:0]    cfg_data  = '0;

  int fail_count;
  int reports_due;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_request  = 0;
  int readings_sent  = 0;
  int quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  battery_pack_monitor u_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  bpm_monitor_checker u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .reports_due
  );

  // Pack one battery reading: index lowest, then taps 0..5, then both temps.
  // Index and temperatures come in as plain integers and are cut to width here.
  function automatic logic [IN_DATA_W-1:0] reading_of(int batt,
                                                      logic [TAPS_W-1:0] taps,
                                                      int temp_a,
                                                      int temp_b);
    return IN_DATA_W'({TEMP_W'(temp_b), TEMP_W'(temp_a), taps, BATT_W'(batt)});
  endfunction

  // Convert cell targets in millivolts to cumulative tap counts. Every cell
  // sits near base with some jitter; one randomly picked cell gets an offset
  // so that spreads land on both sides of the limit.
  function automatic logic [TAPS_W-1:0] cells_to_taps(int base, int jitter, int odd_offset);
    logic [TAPS_W-1:0] taps;
    longint            cum, raw, gain;
    int                odd;
    cum = 0;
    odd = $urandom_range(0, NUM_TAPS - 1);
    for (int k = 0; k < NUM_TAPS; k++) begin
      cum += base + int'($urandom_range(0, 2 * jitter)) - jitter
             + ((k == odd) ? odd_offset : 0);
      gain = longint'(TAP_GAIN_Q16[k]);
      raw  = (cum * 65536 + gain / 2) / gain;
      if (raw > 4095) raw = 4095;
      if (raw < 0) raw = 0;
      taps[RAW_W*k +: RAW_W] = RAW_W'(raw);
    end
    return taps;
  endfunction

  // Mostly room-ish temperatures, now and then anything the field holds.
  function automatic logic [TEMP_W-1:0] pack_temp();
    if ($urandom_range(99) < 90) return TEMP_W'(int'($urandom_range(0, 90)) - 15);
    return TEMP_W'($urandom_range(0, 511));
  endfunction

  task automatic write_reg(cfg_reg_e idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LIMIT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_reading(logic [IN_DATA_W-1:0] d, logic eop);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= eop;
    do @(posedge clk); while (!s_tready);
    readings_sent++;
  endtask

  // Drop valid and wait until every outstanding report has been delivered.
  task automatic drain_reports();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reports_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One well-formed update pass: every battery in order, last one ends it.
  task automatic send_pass();
    int base, offset;
    base = $urandom_range(2800, 4100);
    for (int b = 0; b < NUM_BATTERIES_DEF; b++) begin
      offset = ($urandom_range(99) < 70) ? 0 : int'($urandom_range(0, 3000)) - 1500;
      send_reading(reading_of(b, cells_to_taps(base, $urandom_range(0, 150), offset),
                              int'(pack_temp()), int'(pack_temp())),
                   b == NUM_BATTERIES_DEF - 1);
    end
  endtask

  // Arbitrary bits everywhere, including the unknown battery index.
  task automatic send_noise();
    logic [IN_DATA_W-1:0] d;
    d = {$urandom(), $urandom(), $urandom()};
    d[IN_DATA_W-1:BATT_W + TAPS_W + 2*TEMP_W] = '0;
    send_reading(d, 1'($urandom_range(0, 1)));
  endtask

  task automatic apply_setting(int blk);
    case (blk)
      0: begin  // tightest spread, widest temperature window, no memory
        write_reg(CFG_SPREAD_LIMIT, 0);
        write_reg(CFG_TEMP_HIGH, 255);
        write_reg(CFG_TEMP_LOW, -256);
        write_reg(CFG_AVG_WEIGHT, 0);
      end
      1: begin  // loosest spread, inverted window, frozen averages
        write_reg(CFG_SPREAD_LIMIT, 32767);
        write_reg(CFG_TEMP_HIGH, -256);
        write_reg(CFG_TEMP_LOW, 255);
        write_reg(CFG_AVG_WEIGHT, 256);
      end
      5: begin  // back to power-on values
        write_reg(CFG_SPREAD_LIMIT, 500);
        write_reg(CFG_TEMP_HIGH, 60);
        write_reg(CFG_TEMP_LOW, 0);
        write_reg(CFG_AVG_WEIGHT, 128);
      end
      default: begin
        write_reg(CFG_SPREAD_LIMIT, $urandom_range(0, 1500));
        write_reg(CFG_TEMP_HIGH, $urandom_range(40, 80));
        write_reg(CFG_TEMP_LOW, -int'($urandom_range(0, 20)));
        // Weights past one are clamped by the block; cover them too.
        write_reg(CFG_AVG_WEIGHT, (blk == 2) ? 511 :
                                  (blk == 3) ? $urandom_range(257, 510) :
                                               $urandom_range(0, 256));
      end
    endcase
  endtask

  // Sink: random back-pressure, or one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        m_tready <= 1'b0;
        for (int n = 1; n < stall_request; n++) @(negedge clk);
        stall_request = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TAPS_W-1:0] nominal;
    int                block_start;
    bit                paused;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: the spread limit equals the all-full-scale spread, so the
    // first reading sits exactly on it; averages sit on both limits.
    nominal = cells_to_taps(3700, 0, 0);
    write_reg(CFG_SPREAD_LIMIT, 10000);
    write_reg(CFG_TEMP_HIGH, 60);
    write_reg(CFG_TEMP_LOW, 0);
    write_reg(CFG_AVG_WEIGHT, 128);
    send_reading(reading_of(0, {NUM_TAPS{12'hFFF}}, 60, 0), 1'b1);
    send_reading(reading_of(1, '0, 61, 5), 1'b0);            // just above high
    send_reading(reading_of(2, {NUM_TAPS{12'h555}}, 10, -1), 1'b1);
    send_reading(reading_of(3, {NUM_TAPS{12'hAAA}}, 'h0AA, 'h155), 1'b1);
    send_reading(reading_of(0, {NUM_TAPS{12'hAAA}}, 'h155, 'h0AA), 1'b0);
    send_reading(reading_of(1, '0, -256, 255), 1'b1);

    // One millivolt tighter: the same full-scale reading now trips imbalance.
    drain_reports();
    write_reg(CFG_SPREAD_LIMIT, 9999);
    write_reg(CFG_AVG_WEIGHT, 0);
    send_reading(reading_of(2, {NUM_TAPS{12'hFFF}}, 30, 30), 1'b0);
    send_reading(reading_of(0, {{(TAPS_W-RAW_W){1'b0}}, 12'hFFF}, 20, 20), 1'b1);
    send_reading(reading_of(1, {12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000},
                            255, -256), 1'b0);

    // Full weight on the old average, then a weight beyond one.
    drain_reports();
    write_reg(CFG_AVG_WEIGHT, 256);
    send_reading(reading_of(0, nominal, 100, -100), 1'b0);
    send_reading(reading_of(2, nominal, -100, 100), 1'b1);
    drain_reports();
    write_reg(CFG_AVG_WEIGHT, 300);
    send_reading(reading_of(1, nominal, 0, 0), 1'b0);

    // Half weight with negative odd sums: truncation toward zero.
    drain_reports();
    write_reg(CFG_AVG_WEIGHT, 128);
    write_reg(CFG_SPREAD_LIMIT, 500);
    send_reading(reading_of(2, nominal, -101, -101), 1'b0);
    send_reading(reading_of(0, nominal, -3, -1), 1'b0);
    send_reading(reading_of(1, nominal, 7, -7), 1'b1);
    send_reading(reading_of(3, nominal, -256, 255), 1'b0);
    send_reading(reading_of(3, '0, 0, 0), 1'b1);

    // Random blocks: source/sink idling A then B, then none at all.
    for (int blk = 0; blk < 6; blk++) begin
      drain_reports();
      send_idle_pct = (blk < 2) ? 29 : (blk < 4) ? 58 : 0;
      recv_idle_pct = (blk < 2) ? 58 : (blk < 4) ? 29 : 0;
      apply_setting(blk);
      if (blk == 4) stall_request = LONG_STALL;
      block_start = readings_sent;
      paused = 1'b0;
      while (readings_sent - block_start < BLOCK_READINGS) begin
        // Halfway through one block, hold the source until the sink catches up.
        if (blk == 3 && !paused && readings_sent - block_start >= BLOCK_READINGS / 2) begin
          drain_reports();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) send_pass();
        else send_noise();
      end
    end

    drain_reports();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && reports_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
